### sv/assert_macros.svh
// Assertion macros shared by the relay controller checkers.
// Plain header, no dependencies; take it in with a bare-name include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("relay controller: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("relay controller: next-cycle check failed");

`endif

### sv/rdc_pkg.sv
// Shared types and constants of the relay debounce/cooldown controller.
// No dependencies; used by the interfaces, the RAM user and the checker.
`default_nettype none

package rdc_pkg;

  // Number of relays and field widths
  localparam int unsigned RELAY_COUNT_DEF = 4;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned OVR_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Per-relay phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_ON   = 2'd2,
    PH_COOL = 2'd3
  } phase_e;

  // Override code that lets the machine run
  localparam logic [OVR_W-1:0] OVR_AUTO = 2'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON3  = 3'd5;

  // Configuration reset values
  localparam logic [TIME_W-1:0] TRIGGER_RST  = 32'd6000;
  localparam logic [TIME_W-1:0] COOLDOWN_RST = 32'd10000;
  localparam logic [TIME_W-1:0] MIN_ON_RST   = 32'd30000;

  // One relay's stored state
  typedef struct packed {
    phase_e              phase;
    logic [TIME_W-1:0]   start;
    logic [TIME_W-1:0]   nstart;
    logic                nvalid;
    logic                drive;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

`default_nettype wire

### sv/rdc_if.sv
// Request and result channels of the relay controller (valid/ready).
// Depends on rdc_pkg for field widths.
`default_nettype none

interface rdc_req_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::IDX_W-1:0]   relay_index;
  logic [rdc_pkg::TIME_W-1:0]  now_ms;
  logic                        condition_met;
  logic [rdc_pkg::OVR_W-1:0]   override_mode;

  modport source (output valid, relay_index, now_ms, condition_met, override_mode,
                  input ready);
  modport sink (input valid, relay_index, now_ms, condition_met, override_mode,
                output ready);
endinterface

interface rdc_res_if;
  logic                       valid;
  logic                       ready;
  logic [rdc_pkg::IDX_W-1:0]  relay_id;
  logic                       relay_on;
  logic [1:0]                 phase;

  modport source (output valid, relay_id, relay_on, phase, input ready);
  modport sink (input valid, relay_id, relay_on, phase, output ready);
endinterface

`default_nettype wire

### sv/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
`default_nettype none

module rdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/relay_debounce_cooldown_fsm.sv
// Top level of the relay controller: state RAM, update logic, config registers.
// Depends on rdc_pkg, rdc_req_if/rdc_res_if and rdc_ram.
`default_nettype none

// Per-relay controller with on-debounce, minimum on time, off-debounce and
// cooldown. Each request updates one relay and yields one result: the relay's
// drive bit and phase after the update. One request is taken every clock while
// the result side is not stalled; the request is held in the update stage while
// the relay state RAM is read, then updated, written back and loaded into the
// output register. The last write is forwarded so back-to-back requests to the
// same relay see fresh state. Result-side stalls hold the pipeline. Config
// registers come out of reset at trigger 6000 ms, cooldown 10000 ms and min-on
// 30000 ms per relay; no clearing pass is needed.
module relay_debounce_cooldown_fsm #(
  parameter int unsigned RELAY_COUNT = rdc_pkg::RELAY_COUNT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rdc_req_if.sink                                req_i,
  rdc_res_if.source                              res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rdc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW    = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
  localparam int unsigned NSLOT = 1 << AW;
  localparam logic [rdc_pkg::IDX_W:0] RelayCnt = (rdc_pkg::IDX_W + 1)'(RELAY_COUNT);

  // Configuration registers
  logic [rdc_pkg::TIME_W-1:0] trigger_q;
  logic [rdc_pkg::TIME_W-1:0] cooldown_q;
  logic [rdc_pkg::TIME_W-1:0] min_on_q [4];
  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_off;

  assign cfg_off = cfg_idx_i - rdc_pkg::CFG_MIN_ON0;

  // Write the addressed register; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q  <= rdc_pkg::TRIGGER_RST;
      cooldown_q <= rdc_pkg::COOLDOWN_RST;
      for (int i = 0; i < 4; i++) begin
        min_on_q[i] <= rdc_pkg::MIN_ON_RST;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        rdc_pkg::CFG_TRIGGER:  trigger_q  <= cfg_data_i;
        rdc_pkg::CFG_COOLDOWN: cooldown_q <= cfg_data_i;
        [rdc_pkg::CFG_MIN_ON0:rdc_pkg::CFG_MIN_ON3]: begin
          min_on_q[cfg_off[1:0]] <= cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  // Update stage: request held while the RAM read completes
  logic                          s1_vld_q;
  logic [rdc_pkg::IDX_W-1:0]     s1_idx_q;
  logic [rdc_pkg::TIME_W-1:0]    s1_now_q;
  logic                          s1_cond_q;
  logic [rdc_pkg::OVR_W-1:0]     s1_ovr_q;
  logic                          s1_adv;
  logic                          req_acc;

  // Output register
  logic                          out_vld_q;
  logic [rdc_pkg::IDX_W-1:0]     out_id_q;
  logic                          out_on_q;
  rdc_pkg::phase_e               out_phase_q;

  assign s1_adv  = s1_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !s1_vld_q || s1_adv;
  assign req_acc = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_idx_q  <= req_i.relay_index;
      s1_now_q  <= req_i.now_ms;
      s1_cond_q <= req_i.condition_met;
      s1_ovr_q  <= req_i.override_mode;
    end
  end

  // State RAM and per-entry written flags
  logic [AW-1:0]           s1_addr;
  logic                    s1_in_range;
  logic                    ram_we;
  logic [rdc_pkg::REC_W-1:0] ram_rdata;
  rdc_pkg::rec_t           cur_rec;
  rdc_pkg::rec_t           nxt_rec;
  logic [NSLOT-1:0]        entry_vld_q;
  logic                    wb_vld_q;
  logic [AW-1:0]           wb_addr_q;
  rdc_pkg::rec_t           wb_rec_q;

  assign s1_addr     = s1_idx_q[AW-1:0];
  assign s1_in_range = {1'b0, s1_idx_q} < RelayCnt;
  assign ram_we      = s1_adv && s1_in_range;

  rdc_ram #(
    .WIDTH (rdc_pkg::REC_W),
    .DEPTH (RELAY_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (nxt_rec),
    .re_i    (req_acc),
    .raddr_i (req_i.relay_index[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Track written entries and the most recent write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      wb_vld_q    <= 1'b0;
    end else if (ram_we) begin
      entry_vld_q[s1_addr] <= 1'b1;
      wb_vld_q             <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wb_addr_q <= s1_addr;
      wb_rec_q  <= nxt_rec;
    end
  end

  // Select current state: forwarded write, RAM data, or reset value
  always_comb begin
    if (wb_vld_q && (wb_addr_q == s1_addr)) begin
      cur_rec = wb_rec_q;
    end else if (entry_vld_q[s1_addr]) begin
      cur_rec = rdc_pkg::rec_t'(ram_rdata);
    end else begin
      cur_rec = '0;
    end
  end

  // Next state of the relay machine
  logic [rdc_pkg::TIME_W-1:0] since_start;
  logic [rdc_pkg::TIME_W-1:0] since_normal;

  assign since_start  = s1_now_q - cur_rec.start;
  assign since_normal = s1_now_q - cur_rec.nstart;

  always_comb begin
    nxt_rec = cur_rec;
    if (s1_ovr_q == rdc_pkg::OVR_AUTO) begin
      case (cur_rec.phase)
        rdc_pkg::PH_IDLE: begin
          if (s1_cond_q) begin
            nxt_rec.phase = rdc_pkg::PH_TRIG;
            nxt_rec.start = s1_now_q;
          end
        end
        rdc_pkg::PH_TRIG: begin
          if (!s1_cond_q) begin
            nxt_rec.phase = rdc_pkg::PH_IDLE;
          end else if (since_start >= trigger_q) begin
            nxt_rec.drive  = 1'b1;
            nxt_rec.phase  = rdc_pkg::PH_ON;
            nxt_rec.start  = s1_now_q;
            nxt_rec.nvalid = 1'b0;
            nxt_rec.nstart = '0;
          end
        end
        rdc_pkg::PH_ON: begin
          if (since_start >= min_on_q[s1_idx_q]) begin
            if (!s1_cond_q) begin
              if (!cur_rec.nvalid) begin
                nxt_rec.nstart = s1_now_q;
                nxt_rec.nvalid = 1'b1;
              end else if (since_normal >= trigger_q) begin
                nxt_rec.drive  = 1'b0;
                nxt_rec.phase  = rdc_pkg::PH_COOL;
                nxt_rec.start  = s1_now_q;
                nxt_rec.nvalid = 1'b0;
                nxt_rec.nstart = '0;
              end
            end else begin
              nxt_rec.nvalid = 1'b0;
              nxt_rec.nstart = '0;
            end
          end
        end
        default: begin
          if (since_start >= cooldown_q) begin
            nxt_rec.phase = rdc_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  // Result values: out-of-range relays report off and idle
  logic            res_on;
  rdc_pkg::phase_e res_phase;

  always_comb begin
    if (s1_in_range) begin
      res_on    = nxt_rec.drive;
      res_phase = nxt_rec.phase;
    end else begin
      res_on    = 1'b0;
      res_phase = rdc_pkg::PH_IDLE;
    end
  end

  // Load the output register; drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_id_q    <= s1_idx_q;
      out_on_q    <= res_on;
      out_phase_q <= res_phase;
    end
  end

  assign res_o.valid    = out_vld_q;
  assign res_o.relay_id = out_id_q;
  assign res_o.relay_on = out_on_q;
  assign res_o.phase    = 2'(out_phase_q);

endmodule

`default_nettype wire

### sv/rdc_checker.sv
// Port-level checks of the relay controller, bound to the top level.
// Depends on rdc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rdc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       req_valid_i,
  input wire logic       req_ready_i,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic       res_relay_on_i,
  input wire logic [1:0] res_phase_i
);

  // A stalled result stays offered
  `RDC_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)

  // Drive bit is on exactly in the on phase
  `RDC_ASSERT_IMP(a_drive_phase, clk_i, rst_ni, res_valid_i,
    res_relay_on_i == (res_phase_i == 2'(rdc_pkg::PH_ON)))

  // A fresh result follows an earlier taken request that passed the update stage
  `RDC_ASSERT_IMP(a_res_cause, clk_i, rst_ni, $rose(res_valid_i),
    $past(req_valid_i && req_ready_i, 2))

  // Requests back up only behind a stalled result
  `RDC_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, !req_ready_i,
    res_valid_i && !res_ready_i)

endmodule

bind relay_debounce_cooldown_fsm rdc_checker u_rdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_relay_on_i (res_o.relay_on),
  .res_phase_i    (res_o.phase)
);

`default_nettype wire

### sim/relay_debounce_cooldown_fsm_test.sv
// Self-checking testbench for the relay debounce/cooldown controller.
// Depends on rdc_pkg, rdc_req_if/rdc_res_if and relay_debounce_cooldown_fsm.
`default_nettype none

module relay_debounce_cooldown_fsm_test;
  import rdc_pkg::*;

  localparam int CHUNKS       = 10;
  localparam int CHUNK_ITEMS  = 113;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_REPORTS  = 10;

  // Register indexes past the last min-on register; the block must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_MIN_ON3 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_MIN_ON3 + 3'd2;

  typedef enum int {
    SET_DEFAULT, SET_SMALL, SET_ZERO, SET_MAX, SET_MIXED, SET_WIDE
  } setting_e;

  typedef struct {
    logic [IDX_W-1:0]  relay_index;
    logic [TIME_W-1:0] now_ms;
    logic              condition_met;
    logic [OVR_W-1:0]  override_mode;
  } relay_update_t;

  typedef struct {
    logic [IDX_W-1:0] relay_id;
    logic             relay_on;
    phase_e           phase;
  } relay_result_t;

  logic clk_i;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rdc_req_if req_ch ();
  rdc_res_if res_ch ();

  relay_debounce_cooldown_fsm DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .req_i      (req_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predicted controller state, starting from its reset values
  logic [TIME_W-1:0] trigger_ms = TRIGGER_RST;
  logic [TIME_W-1:0] cooldown_ms = COOLDOWN_RST;
  logic [TIME_W-1:0] min_on_ms [4] = '{MIN_ON_RST, MIN_ON_RST, MIN_ON_RST, MIN_ON_RST};
  phase_e            relay_phase [4] = '{PH_IDLE, PH_IDLE, PH_IDLE, PH_IDLE};
  logic [TIME_W-1:0] phase_start [4] = '{0, 0, 0, 0};
  logic [TIME_W-1:0] normal_start [4] = '{0, 0, 0, 0};
  logic              normal_seen [4] = '{0, 0, 0, 0};
  logic              relay_drive [4] = '{0, 0, 0, 0};

  relay_update_t update_queue [$];
  relay_result_t pending_results [$];
  int            accepted_count = 0;
  int            result_count = 0;
  int            mismatches = 0;
  logic          steady = 1'b0;
  logic          hold_off;

  // Stimulus generator state
  logic [TIME_W-1:0] relay_now [4];
  logic              cond_level [4];
  logic [IDX_W-1:0]  last_relay;
  logic [TIME_W-1:0] time_span;

  // Advance one relay by one request and return what the block should report
  function automatic relay_result_t advance_relay(input logic [IDX_W-1:0] idx,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic cond,
                                                  input logic [OVR_W-1:0] ovr);
    relay_result_t r;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] normal_elapsed;
    elapsed = now - phase_start[idx];
    normal_elapsed = now - normal_start[idx];
    if (ovr == OVR_AUTO) begin
      case (relay_phase[idx])
        PH_IDLE: begin
          if (cond) begin
            relay_phase[idx] = PH_TRIG;
            phase_start[idx] = now;
          end
        end
        PH_TRIG: begin
          if (!cond) begin
            relay_phase[idx] = PH_IDLE;
          end else if (elapsed >= trigger_ms) begin
            relay_drive[idx] = 1'b1;
            relay_phase[idx] = PH_ON;
            phase_start[idx] = now;
            normal_seen[idx] = 1'b0;
            normal_start[idx] = '0;
          end
        end
        PH_ON: begin
          if (elapsed >= min_on_ms[idx]) begin
            if (cond) begin
              normal_seen[idx] = 1'b0;
              normal_start[idx] = '0;
            end else if (!normal_seen[idx]) begin
              normal_start[idx] = now;
              normal_seen[idx] = 1'b1;
            end else if (normal_elapsed >= trigger_ms) begin
              relay_drive[idx] = 1'b0;
              relay_phase[idx] = PH_COOL;
              phase_start[idx] = now;
              normal_seen[idx] = 1'b0;
              normal_start[idx] = '0;
            end
          end
        end
        default: begin
          if (elapsed >= cooldown_ms) relay_phase[idx] = PH_IDLE;
        end
      endcase
    end
    r.relay_id = idx;
    r.relay_on = relay_drive[idx];
    r.phase = relay_phase[idx];
    return r;
  endfunction

  // Queue one request for the driver
  task automatic queue_update(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] now,
                              input logic cond, input logic [OVR_W-1:0] ovr);
    relay_update_t u;
    u.relay_index = idx;
    u.now_ms = now;
    u.condition_met = cond;
    u.override_mode = ovr;
    update_queue.push_back(u);
  endtask

  // Build a mostly coherent request: per-relay time that moves forward, often
  // by one of the thresholds or one less, and condition levels that persist
  task automatic queue_random_update();
    logic [IDX_W-1:0] idx;
    logic [TIME_W-1:0] step;
    logic [OVR_W-1:0] ovr;
    if ($urandom_range(0, 3) == 0) idx = IDX_W'($urandom_range(0, 3));
    else idx = last_relay;
    last_relay = idx;
    case ($urandom_range(0, 9))
      0: relay_now[idx] = $urandom();
      1, 2: begin
        case ($urandom_range(0, 2))
          0: step = trigger_ms;
          1: step = cooldown_ms;
          default: step = min_on_ms[idx];
        endcase
        relay_now[idx] = relay_now[idx] + step - $urandom_range(0, 1);
      end
      default: relay_now[idx] = relay_now[idx] + $urandom_range(0, time_span);
    endcase
    if ($urandom_range(0, 3) == 0) cond_level[idx] = !cond_level[idx];
    if ($urandom_range(0, 9) == 0) ovr = OVR_W'($urandom_range(1, 3));
    else ovr = OVR_AUTO;
    queue_update(idx, relay_now[idx], cond_level[idx], ovr);
  endtask

  // Write one register and mirror it in the predicted configuration
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx == CFG_TRIGGER) trigger_ms = data;
    else if (idx == CFG_COOLDOWN) cooldown_ms = data;
    else if (idx >= CFG_MIN_ON0 && idx <= CFG_MIN_ON3) min_on_ms[idx - CFG_MIN_ON0] = data;
  endtask

  // Load a full configuration, plus junk to the unused indexes
  task automatic apply_setting(input setting_e kind);
    logic [TIME_W-1:0] trig;
    logic [TIME_W-1:0] cool;
    logic [TIME_W-1:0] on_time [4];
    case (kind)
      SET_DEFAULT: begin
        trig = TRIGGER_RST;
        cool = COOLDOWN_RST;
        on_time = '{MIN_ON_RST, MIN_ON_RST, MIN_ON_RST, MIN_ON_RST};
        time_span = 8000;
      end
      SET_SMALL: begin
        trig = 5;
        cool = 8;
        on_time = '{10, 0, 3, 20};
        time_span = 12;
      end
      SET_ZERO: begin
        trig = 0;
        cool = 0;
        on_time = '{0, 0, 0, 0};
        time_span = 3;
      end
      SET_MAX: begin
        trig = '1;
        cool = '1;
        on_time = '{'1, '1, '1, '1};
        time_span = '1;
      end
      SET_MIXED: begin
        trig = $urandom_range(0, 50);
        cool = $urandom_range(0, 80);
        foreach (on_time[i]) on_time[i] = $urandom_range(0, 100);
        time_span = 60;
      end
      default: begin
        trig = $urandom();
        cool = $urandom();
        foreach (on_time[i]) on_time[i] = $urandom();
        time_span = $urandom();
      end
    endcase
    write_register(CFG_TRIGGER, trig);
    write_register(CFG_COOLDOWN, cool);
    foreach (on_time[i]) write_register(CFG_IDX_W'(CFG_MIN_ON0 + i), on_time[i]);
    write_register(CFG_SPARE_A, $urandom());
    write_register(CFG_SPARE_B, $urandom());
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued request has gone through and been checked
  task automatic wait_idle();
    while (update_queue.size() != 0 || req_ch.valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Request driver: offer the next queued request after a random gap (none when steady)
  int req_gap = 0;
  always @(posedge clk_i) begin
    relay_update_t u;
    if (rst_n) begin
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_ch.valid <= 1'b0;
          req_gap = req_gap - 1;
        end else if (update_queue.size() != 0) begin
          u = update_queue.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.relay_index <= u.relay_index;
          req_ch.now_ms <= u.now_ms;
          req_ch.condition_met <= u.condition_met;
          req_ch.override_mode <= u.override_mode;
          req_gap = steady ? 0 : $urandom_range(0, 6);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Predict on each accepted request, check each accepted result, pace ready
  int res_stall = 0;
  always @(posedge clk_i) begin
    relay_result_t expd;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(advance_relay(req_ch.relay_index, req_ch.now_ms,
                                                req_ch.condition_met, req_ch.override_mode));
        accepted_count++;
      end
      if (res_ch.valid && res_ch.ready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("result %0d: unexpected, relay %0d on %0b phase %0d", result_count,
                     res_ch.relay_id, res_ch.relay_on, res_ch.phase);
          mismatches++;
        end else begin
          expd = pending_results.pop_front();
          if (res_ch.relay_id !== expd.relay_id || res_ch.relay_on !== expd.relay_on ||
              res_ch.phase !== expd.phase) begin
            if (mismatches < MAX_REPORTS)
              $display("result %0d: expected relay %0d on %0b phase %0d, got %0d %0b %0d",
                       result_count, expd.relay_id, expd.relay_on, expd.phase,
                       res_ch.relay_id, res_ch.relay_on, res_ch.phase);
            mismatches++;
          end
        end
        res_stall = steady ? 0 : $urandom_range(0, 6);
      end
      if (hold_off) begin
        res_ch.ready <= 1'b0;
      end else if (res_stall > 0) begin
        res_ch.ready <= 1'b0;
        res_stall = res_stall - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Block the result side for a long stretch while requests keep coming
  initial begin
    hold_off = 1'b0;
    while (!(accepted_count >= 60 && update_queue.size() >= 30)) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence: reset, directed requests, then random chunks per setting
  initial begin
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] t_on;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.relay_index = '0;
    req_ch.now_ms = '0;
    req_ch.condition_met = 1'b0;
    req_ch.override_mode = OVR_AUTO;
    res_ch.ready = 1'b0;
    foreach (relay_now[i]) begin
      relay_now[i] = $urandom();
      cond_level[i] = 1'b0;
    end
    last_relay = '0;
    time_span = 8000;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // Relay 0: full cycle under reset config, with the turn-on time wrapping
    t = 32'hFFFF_F000;
    t_on = t + 32'd6000;
    queue_update(0, t, 1'b1, OVR_AUTO);
    queue_update(0, t + 32'd5999, 1'b1, OVR_AUTO);
    queue_update(0, t_on, 1'b1, OVR_AUTO);
    queue_update(0, t_on + 32'd100, 1'b0, OVR_AUTO + 2'd1);
    queue_update(0, t_on + 32'd200, 1'b0, OVR_AUTO + 2'd2);
    queue_update(0, t_on + 32'd300, 1'b0, OVR_AUTO + 2'd3);
    queue_update(0, t_on + 32'd29999, 1'b0, OVR_AUTO);
    queue_update(0, t_on + 32'd30000, 1'b0, OVR_AUTO);
    queue_update(0, t_on + 32'd31000, 1'b1, OVR_AUTO);
    queue_update(0, t_on + 32'd31001, 1'b0, OVR_AUTO);
    queue_update(0, t_on + 32'd37000, 1'b0, OVR_AUTO);
    queue_update(0, t_on + 32'd37001, 1'b0, OVR_AUTO);
    queue_update(0, t_on + 32'd47000, 1'b0, OVR_AUTO);
    queue_update(0, t_on + 32'd47001, 1'b1, OVR_AUTO);
    queue_update(0, t_on + 32'd47002, 1'b1, OVR_AUTO);
    // Relay 1: condition drops during the on-debounce
    queue_update(1, 32'd0, 1'b1, OVR_AUTO);
    queue_update(1, 32'd1, 1'b0, OVR_AUTO);
    // Relay 2: off-debounce starts at timestamp zero
    t = 32'd0 - 32'd36000;
    queue_update(2, t, 1'b1, OVR_AUTO);
    queue_update(2, t + 32'd6000, 1'b1, OVR_AUTO);
    queue_update(2, 32'd0, 1'b0, OVR_AUTO);
    queue_update(2, 32'd6000, 1'b0, OVR_AUTO);
    // Relay 3: manual off freezes idle, then automatic resumes
    queue_update(3, 32'hFFFF_FFFF, 1'b1, OVR_AUTO + 2'd2);
    queue_update(3, 32'hFFFF_FFFF, 1'b1, OVR_AUTO);
    queue_update(3, 32'd0, 1'b0, OVR_AUTO);
    wait_idle();

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      apply_setting(setting_e'(chunk % 6));
      steady = (chunk % 3 == 2);
      for (int n = 0; n < CHUNK_ITEMS; n++) queue_random_update();
      wait_idle();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
